>>> hw/rtl/eltzs_pkg.sv
package eltzs_pkg;

  // Pre-trigger store
  localparam int PRE_MAX = 16;
  localparam int PRE_AW  = (PRE_MAX > 1) ? $clog2(PRE_MAX) : 1;
  localparam int PRE_FW  = $clog2(PRE_MAX + 1);

  // Field widths
  localparam int WORD_W          = 32;
  localparam int IDX_W           = 31;
  localparam int TS_W            = 24;
  localparam int LEN_W           = 8;
  localparam int OFFSET_W        = 8;
  localparam int RATIO_W         = 24;
  localparam int RATIO_FRAC_BITS = 16;
  localparam int PRE_CNT_W       = 5;
  localparam int POST_CNT_W      = 16;

  localparam logic [IDX_W-1:0]  IDX_MAX  = '1;
  localparam logic [WORD_W-1:0] ONE_BITS = 32'h3F80_0000;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_COUNT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POST_COUNT = 2'd3;

  localparam logic [RATIO_W-1:0] RATIO_RESET = 24'h01_0000;

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  // Result queue at the output
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

  typedef logic [1:0] cmd_op_t;
  localparam cmd_op_t CMD_CLEAR = 2'd0;  // drop pre-trigger content
  localparam cmd_op_t CMD_PUSH  = 2'd1;  // store a below-threshold sample
  localparam cmd_op_t CMD_EMIT  = 2'd2;  // emit one point, last of its word
  localparam cmd_op_t CMD_TRIG  = 2'd3;  // flush pre-trigger store, then emit

  typedef struct packed {
    cmd_op_t           op;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] val;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] val;
    logic              last;
  } res_t;

  typedef struct packed {
    logic hdr_wait;
    logic scaling;
  } front_stat_t;

  typedef struct packed {
    logic              flushing;
    logic [PRE_FW-1:0] fill;
  } back_stat_t;

endpackage

>>> hw/rtl/eltzs_front.sv
module eltzs_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 push,
  input  logic [eltzs_pkg::WORD_W-1:0]         event_word,
  output logic                                 full,
  input  logic [eltzs_pkg::RATIO_W-1:0]        ratio,
  input  logic [eltzs_pkg::WORD_W-1:0]         threshold,
  input  logic [eltzs_pkg::PRE_FW-1:0]         keep,
  input  logic [eltzs_pkg::POST_CNT_W-1:0]     post_count,
  output eltzs_pkg::cmd_t                      cmd,
  output logic                                 cmd_push,
  input  logic                                 cmdq_full,
  output eltzs_pkg::front_stat_t               stat
);
  import eltzs_pkg::*;

  localparam int PROD_W  = TS_W + RATIO_W;
  localparam int SHIFT_W = PROD_W + 1 - RATIO_FRAC_BITS;
  localparam logic [PROD_W:0] ROUND_HALF = (PROD_W+1)'(1) << (RATIO_FRAC_BITS - 1);

  localparam logic F_RUN   = 1'b0;
  localparam logic F_SCALE = 1'b1;

  logic                  state_r, state_nxt;
  logic [LEN_W-1:0]      remaining_r, remaining_nxt;
  logic [IDX_W-1:0]      base_r, base_nxt;
  logic [OFFSET_W-1:0]   offset_r, offset_nxt;
  logic                  peak_r, peak_nxt;
  logic [POST_CNT_W-1:0] post_r, post_nxt;
  logic [PROD_W-1:0]     prod_r;
  logic [LEN_W-1:0]      len_r;

  logic                  accept;
  logic                  hdr_accept;
  logic [PROD_W:0]       rnd_sum;
  logic [SHIFT_W-1:0]    shifted;
  logic [IDX_W-1:0]      scaled;
  logic [IDX_W:0]        idx_sum;
  logic [IDX_W-1:0]      samp_idx;
  logic                  nan;
  logic                  lt;
  logic                  ge;

  function automatic logic f32_is_nan(input logic [WORD_W-1:0] b);
    f32_is_nan = b[WORD_W-2:0] > 31'h7F80_0000;
  endfunction

  // Map IEEE bits onto an unsigned key that sorts like the float values.
  function automatic logic [WORD_W-1:0] order_key(input logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] mag;
    mag = {1'b0, b[WORD_W-2:0]};
    order_key = b[WORD_W-1] ? (32'h8000_0000 - mag) : (32'h8000_0000 + mag);
  endfunction

  assign full       = (state_r == F_SCALE) || cmdq_full;
  assign accept     = push && !full;
  assign hdr_accept = accept && (remaining_r == '0);

  assign stat.hdr_wait = (state_r == F_RUN) && (remaining_r == '0);
  assign stat.scaling  = (state_r == F_SCALE);

  // Round half up, then saturate to the index range.
  assign rnd_sum = {1'b0, prod_r} + ROUND_HALF;
  assign shifted = rnd_sum[PROD_W:RATIO_FRAC_BITS];
  assign scaled  = (shifted > SHIFT_W'(IDX_MAX)) ? IDX_MAX : shifted[IDX_W-1:0];

  assign idx_sum  = {1'b0, base_r} + (IDX_W+1)'(offset_r);
  assign samp_idx = idx_sum[IDX_W] ? IDX_MAX : idx_sum[IDX_W-1:0];

  assign nan = f32_is_nan(event_word) || f32_is_nan(threshold);
  assign lt  = !nan && (order_key(event_word) <  order_key(threshold));
  assign ge  = !nan && (order_key(event_word) >= order_key(threshold));

  always_comb begin
    state_nxt     = state_r;
    remaining_nxt = remaining_r;
    base_nxt      = base_r;
    offset_nxt    = offset_r;
    peak_nxt      = peak_r;
    post_nxt      = post_r;
    cmd_push      = 1'b0;
    cmd           = '{op: CMD_EMIT, idx: samp_idx, val: event_word};
    unique case (state_r)
      F_RUN: begin
        if (accept) begin
          if (remaining_r == '0) begin
            state_nxt = F_SCALE;
          end else begin
            offset_nxt    = offset_r + OFFSET_W'(1);
            remaining_nxt = remaining_r - LEN_W'(1);
            if (lt && !peak_r && (keep != '0)) begin
              cmd_push = 1'b1;
              cmd.op   = CMD_PUSH;
            end
            if (ge) begin
              cmd_push = 1'b1;
              if (!peak_r) begin
                peak_nxt = 1'b1;
                cmd.op   = (keep != '0) ? CMD_TRIG : CMD_EMIT;
              end
            end
            if (lt && peak_r) begin
              if (post_r < post_count) begin
                cmd_push = 1'b1;
                post_nxt = post_r + POST_CNT_W'(1);
              end else begin
                peak_nxt = 1'b0;
                post_nxt = '0;
              end
            end
          end
        end
      end
      F_SCALE: begin
        if (!cmdq_full) begin
          cmd_push  = 1'b1;
          cmd.idx   = scaled;
          state_nxt = F_RUN;
          if (len_r == '0) begin
            cmd.op  = CMD_EMIT;
            cmd.val = ONE_BITS;
          end else begin
            cmd.op        = CMD_CLEAR;
            base_nxt      = scaled;
            remaining_nxt = len_r;
            offset_nxt    = '0;
            post_nxt      = '0;
            peak_nxt      = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = F_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_RUN;
      remaining_r <= '0;
      base_r      <= '0;
      offset_r    <= '0;
      peak_r      <= 1'b0;
      post_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      remaining_r <= remaining_nxt;
      base_r      <= base_nxt;
      offset_r    <= offset_nxt;
      peak_r      <= peak_nxt;
      post_r      <= post_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_accept) begin
      prod_r <= PROD_W'(event_word[TS_W-1:0]) * PROD_W'(ratio);
      len_r  <= event_word[WORD_W-1:TS_W];
    end
  end

endmodule

>>> hw/rtl/eltzs_cmdq.sv
module eltzs_cmdq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  eltzs_pkg::cmd_t wr_data,
  output logic            full,
  input  logic            rd_en,
  output eltzs_pkg::cmd_t rd_data,
  output logic            empty
);
  import eltzs_pkg::*;

  cmd_t               slot_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMDQ_CW-1:0] count_r;
  logic               do_wr;
  logic               do_rd;

  assign full    = (count_r == CMDQ_CW'(CMDQ_DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + CMDQ_AW'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + CMDQ_AW'(1);
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + CMDQ_CW'(1);
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - CMDQ_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> hw/rtl/eltzs_back.sv
module eltzs_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  eltzs_pkg::cmd_t              cmd,
  input  logic                         cmd_empty,
  output logic                         cmd_pop,
  input  logic [eltzs_pkg::PRE_FW-1:0] keep,
  output eltzs_pkg::res_t              res,
  output logic                         res_empty,
  input  logic                         res_pop,
  output eltzs_pkg::back_stat_t        stat
);
  import eltzs_pkg::*;

  localparam logic B_IDLE  = 1'b0;
  localparam logic B_FLUSH = 1'b1;

  logic              state_r, state_nxt;
  logic [PRE_FW-1:0] fill_r, fill_nxt;
  logic [PRE_AW-1:0] head_r, head_nxt;
  logic [IDX_W-1:0]  pre_idx_r [PRE_MAX];
  logic [WORD_W-1:0] pre_val_r [PRE_MAX];
  logic [IDX_W-1:0]  trig_idx_r;
  logic [WORD_W-1:0] trig_val_r;

  res_t               oq_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] oq_wr_r, oq_rd_r;
  logic [OUTQ_CW-1:0] oq_cnt_r;
  logic               oq_room;
  logic               oq_wr;
  logic               oq_rd;
  res_t               oq_data;

  logic              pre_we;
  logic [PRE_AW-1:0] pre_pos;
  logic [PRE_FW-1:0] kept;
  logic [PRE_FW-1:0] drop;
  logic              trig_take;

  function automatic logic [PRE_AW-1:0] ring_add(input logic [PRE_AW-1:0] a,
                                                 input logic [PRE_FW-1:0] b);
    logic [PRE_FW:0] s;
    s = (PRE_FW+1)'(a) + (PRE_FW+1)'(b);
    if (s >= (PRE_FW+1)'(PRE_MAX)) begin
      s = s - (PRE_FW+1)'(PRE_MAX);
    end
    ring_add = s[PRE_AW-1:0];
  endfunction

  assign oq_room   = (oq_cnt_r != OUTQ_CW'(OUTQ_DEPTH));
  assign res_empty = (oq_cnt_r == '0);
  assign oq_rd     = res_pop && !res_empty;
  assign res       = oq_r[oq_rd_r];

  assign stat.flushing = (state_r == B_FLUSH);
  assign stat.fill     = fill_r;

  // Drop the oldest entries until one slot below the keep depth is left.
  assign kept    = (fill_r < keep) ? fill_r : keep - PRE_FW'(1);
  assign drop    = fill_r - kept;
  assign pre_pos = ring_add(head_r, fill_r);

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    head_nxt  = head_r;
    cmd_pop   = 1'b0;
    pre_we    = 1'b0;
    trig_take = 1'b0;
    oq_wr     = 1'b0;
    oq_data   = '{idx: cmd.idx, val: cmd.val, last: 1'b1};
    unique case (state_r)
      B_IDLE: begin
        if (!cmd_empty) begin
          unique case (cmd.op)
            CMD_CLEAR: begin
              cmd_pop  = 1'b1;
              fill_nxt = '0;
              head_nxt = '0;
            end
            CMD_PUSH: begin
              cmd_pop  = 1'b1;
              pre_we   = 1'b1;
              fill_nxt = kept + PRE_FW'(1);
              head_nxt = ring_add(head_r, drop);
            end
            CMD_EMIT: begin
              if (oq_room) begin
                cmd_pop = 1'b1;
                oq_wr   = 1'b1;
              end
            end
            CMD_TRIG: begin
              cmd_pop   = 1'b1;
              trig_take = 1'b1;
              state_nxt = B_FLUSH;
            end
            default: ;
          endcase
        end
      end
      B_FLUSH: begin
        if (oq_room) begin
          oq_wr = 1'b1;
          if (fill_r != '0) begin
            oq_data  = '{idx: pre_idx_r[head_r], val: pre_val_r[head_r], last: 1'b0};
            head_nxt = ring_add(head_r, PRE_FW'(1));
            fill_nxt = fill_r - PRE_FW'(1);
          end else begin
            oq_data   = '{idx: trig_idx_r, val: trig_val_r, last: 1'b1};
            head_nxt  = '0;
            state_nxt = B_IDLE;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      fill_r   <= '0;
      head_r   <= '0;
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      head_r  <= head_nxt;
      if (oq_wr) begin
        oq_wr_r <= (oq_wr_r == OUTQ_AW'(OUTQ_DEPTH - 1)) ? '0 : oq_wr_r + OUTQ_AW'(1);
      end
      if (oq_rd) begin
        oq_rd_r <= (oq_rd_r == OUTQ_AW'(OUTQ_DEPTH - 1)) ? '0 : oq_rd_r + OUTQ_AW'(1);
      end
      if (oq_wr && !oq_rd) begin
        oq_cnt_r <= oq_cnt_r + OUTQ_CW'(1);
      end else if (oq_rd && !oq_wr) begin
        oq_cnt_r <= oq_cnt_r - OUTQ_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pre_we) begin
      pre_idx_r[pre_pos] <= cmd.idx;
      pre_val_r[pre_pos] <= cmd.val;
    end
    if (trig_take) begin
      trig_idx_r <= cmd.idx;
      trig_val_r <= cmd.val;
    end
    if (oq_wr) begin
      oq_r[oq_wr_r] <= oq_data;
    end
  end

endmodule

>>> hw/rtl/event_list_threshold_zero_suppressor.sv
// Zero suppressor for a digitizer event list with pre- and post-trigger samples.
// Input side is a queue write port: present in_event_word with push; the word
// is taken at a clock edge where push is high and full is low. Result side is a
// queue read port: while empty is low the oldest result sits on out_*; pop takes
// it. out_last_of_run marks the final result caused by one input word.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_data); write it
// only while the block is idle.
// Throughput: one sample word per cycle while the command queue has room; a header
// word blocks the input while its timestamp is scaled (the multiply is registered
// before rounding). A threshold crossing with pre-trigger content produces fill + 1
// results, drained by the back end at one result per cycle while the result queue
// has room; the four-deep command queue keeps taking input meanwhile. A result
// passes the command queue, then the result queue. A crossing with a pre-trigger
// depth set first enters the flush, then emits the stored points, oldest first.
// Reset (rst_n low, synchronous) empties both queues, expects a header next and
// restores the register defaults (ratio 1.0, threshold 0, no pre/post samples).
// A stalled receiver fills the result queue, then the command queue, and full
// rises; nothing is dropped.
module event_list_threshold_zero_suppressor (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic [eltzs_pkg::WORD_W-1:0]    in_event_word,
  output logic                            empty,
  input  logic                            pop,
  output logic [eltzs_pkg::IDX_W-1:0]     out_sample_index,
  output logic [eltzs_pkg::WORD_W-1:0]    out_value_bits,
  output logic                            out_last_of_run,
  input  logic                            cfg_wr_en,
  input  logic [eltzs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [eltzs_pkg::WORD_W-1:0]    cfg_data
);
  import eltzs_pkg::*;

  // Configuration registers
  logic [RATIO_W-1:0]    ratio_r;
  logic [WORD_W-1:0]     threshold_r;
  logic [PRE_CNT_W-1:0]  pre_count_r;
  logic [POST_CNT_W-1:0] post_count_r;
  logic [PRE_FW-1:0]     keep;

  cmd_t        fe_cmd;
  logic        fe_cmd_push;
  cmd_t        cq_cmd;
  logic        cq_full;
  logic        cq_empty;
  logic        be_cmd_pop;
  res_t        be_res;
  front_stat_t fe_stat;
  back_stat_t  be_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r      <= RATIO_RESET;
      threshold_r  <= '0;
      pre_count_r  <= '0;
      post_count_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_RATIO:      ratio_r      <= cfg_data[RATIO_W-1:0];
        REG_THRESHOLD:  threshold_r  <= cfg_data;
        REG_PRE_COUNT:  pre_count_r  <= cfg_data[PRE_CNT_W-1:0];
        REG_POST_COUNT: post_count_r <= cfg_data[POST_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the pre-trigger depth to the store size.
  assign keep = (pre_count_r > PRE_CNT_W'(PRE_MAX)) ? PRE_FW'(PRE_MAX) : PRE_FW'(pre_count_r);

  // Front: parse headers, scale timestamps, gate samples, issue commands.
  eltzs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .event_word (in_event_word),
    .full       (full),
    .ratio      (ratio_r),
    .threshold  (threshold_r),
    .keep       (keep),
    .post_count (post_count_r),
    .cmd        (fe_cmd),
    .cmd_push   (fe_cmd_push),
    .cmdq_full  (cq_full),
    .stat       (fe_stat)
  );

  // Hold commands so a flush burst does not stall the input.
  eltzs_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fe_cmd_push),
    .wr_data (fe_cmd),
    .full    (cq_full),
    .rd_en   (be_cmd_pop),
    .rd_data (cq_cmd),
    .empty   (cq_empty)
  );

  // Back: own the pre-trigger store, flush it on a crossing, queue results.
  eltzs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cq_cmd),
    .cmd_empty (cq_empty),
    .cmd_pop   (be_cmd_pop),
    .keep      (keep),
    .res       (be_res),
    .res_empty (empty),
    .res_pop   (pop),
    .stat      (be_stat)
  );

  assign out_sample_index = be_res.idx;
  assign out_value_bits   = be_res.val;
  assign out_last_of_run  = be_res.last;

  // An accepted header raises full once the front starts scaling it.
  a_hdr_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    push && !full && fe_stat.hdr_wait |=> full)
    else $error("input not blocked while scaling a header");

  // Hold the input off for as long as the front scales a timestamp.
  a_scale_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    fe_stat.scaling |-> full)
    else $error("input open while scaling a header");

  // A flush only drains the pre-trigger store.
  a_flush_drains: assert property (@(posedge clk) disable iff (!rst_n)
    be_stat.flushing |=> be_stat.fill <= $past(be_stat.fill))
    else $error("pre-trigger fill grew during a flush");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    be_stat.fill <= PRE_FW'(PRE_MAX))
    else $error("pre-trigger fill exceeds store depth");

  // Reset leaves no stale results.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

endmodule

>>> test/event_list_threshold_zero_suppressor_test.sv
`timescale 1ns / 1ps

module event_list_threshold_zero_suppressor_test;
  import eltzs_pkg::*;

  // Give up well past the slowest legal run: every point waiting out long pop stalls.
  localparam int CYCLE_LIMIT = 600000;
  // Cover the pipeline and command queue after the last point has been popped.
  localparam int SETTLE_CYCLES = 24;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] val;
    logic              last;
  } point_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 push = 1'b0;
  logic [WORD_W-1:0]    in_event_word = '0;
  logic                 pop = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_RATIO;
  logic [WORD_W-1:0]    cfg_data = '0;
  logic                 full;
  logic                 empty;
  logic [IDX_W-1:0]     out_sample_index;
  logic [WORD_W-1:0]    out_value_bits;
  logic                 out_last_of_run;

  event_list_threshold_zero_suppressor dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_event_word    (in_event_word),
    .empty            (empty),
    .pop              (pop),
    .out_sample_index (out_sample_index),
    .out_value_bits   (out_value_bits),
    .out_last_of_run  (out_last_of_run),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Register copies, starting at their reset values.
  logic [RATIO_W-1:0]    ratio_q      = RATIO_RESET;
  logic [WORD_W-1:0]     threshold_q  = '0;
  logic [PRE_CNT_W-1:0]  pre_keep_q   = '0;
  logic [POST_CNT_W-1:0] post_limit_q = '0;

  // Packet parser and trigger state of the suppressor.
  logic [LEN_W-1:0]      words_left  = '0;
  logic [IDX_W-1:0]      packet_base = '0;
  logic [OFFSET_W-1:0]   packet_pos  = '0;
  bit                    peak_open   = 1'b0;
  logic [POST_CNT_W-1:0] post_sent   = '0;

  // Pre-trigger store: a ring of PRE_MAX entries.
  logic [IDX_W-1:0]  hold_idx [PRE_MAX];
  logic [WORD_W-1:0] hold_val [PRE_MAX];
  int                hold_fill = 0;
  int                hold_head = 0;

  // Points predicted but not yet popped, oldest first.
  point_t pending_points[$];

  int  send_idle_pct = 37;
  int  recv_idle_pct = 49;
  bit  level_high = 1'b0;
  int  cycle_count = 0;
  int  fail_count = 0;
  int  words_sent = 0;
  int  points_checked = 0;
  int  tdc_hits = 0;
  int  crossings = 0;
  int  max_burst = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // IEEE total order on non-NaN values, with -0 and +0 mapping to the same key.
  function automatic logic [31:0] order_key(input logic [31:0] b);
    return b[31] ? (32'h8000_0000 - {1'b0, b[30:0]}) : (32'h8000_0000 + {1'b0, b[30:0]});
  endfunction

  function automatic bit is_nan(input logic [31:0] b);
    return b[30:0] > 31'h7F80_0000;
  endfunction

  // Scale a timestamp by the UQ8.16 ratio, round half up and saturate.
  function automatic logic [IDX_W-1:0] scaled_index(input logic [TS_W-1:0] ts);
    logic [63:0] p;
    p = 64'(ts) * 64'(ratio_q);
    p = (p + (64'd1 << (RATIO_FRAC_BITS - 1))) >> RATIO_FRAC_BITS;
    return (p > 64'(IDX_MAX)) ? IDX_MAX : p[IDX_W-1:0];
  endfunction

  // Advance the predicted state by one accepted word and queue the points it causes.
  function automatic void predict_points(input logic [WORD_W-1:0] w);
    logic [31:0]      idx_sum;
    logic [IDX_W-1:0] idx;
    int               keep;
    bit               nan_cmp;
    bit               lt;
    bit               ge;
    point_t           burst[$];

    if (words_left == 0) begin
      if (w[31:24] == 0) begin
        // TDC hit: one point of value 1.0, trigger state untouched.
        pending_points.push_back('{scaled_index(w[TS_W-1:0]), ONE_BITS, 1'b1});
        tdc_hits++;
        if (max_burst < 1) max_burst = 1;
        return;
      end
      // ADC header: start a packet and forget any trigger history.
      packet_base = scaled_index(w[TS_W-1:0]);
      words_left  = w[31:24];
      packet_pos  = '0;
      hold_fill   = 0;
      hold_head   = 0;
      post_sent   = '0;
      peak_open   = 1'b0;
      return;
    end

    keep = (pre_keep_q > PRE_MAX) ? PRE_MAX : int'(pre_keep_q);
    idx_sum = {1'b0, packet_base} + {24'd0, packet_pos};
    idx = (idx_sum > 32'(IDX_MAX)) ? IDX_MAX : idx_sum[IDX_W-1:0];
    nan_cmp = is_nan(w) || is_nan(threshold_q);
    lt = !nan_cmp && (order_key(w) < order_key(threshold_q));
    ge = !nan_cmp && !lt;

    if (keep > 0 && lt && !peak_open) begin
      // Drop the oldest entries until there is room under the current keep count.
      while (hold_fill > 0 && hold_fill >= keep) begin
        hold_head = (hold_head + 1) % PRE_MAX;
        hold_fill--;
      end
      hold_idx[(hold_head + hold_fill) % PRE_MAX] = idx;
      hold_val[(hold_head + hold_fill) % PRE_MAX] = w;
      hold_fill++;
    end

    if (ge && !peak_open) begin
      peak_open = 1'b1;
      crossings++;
      // With keep zero the store is left alone, stale content included.
      if (keep > 0) begin
        while (hold_fill > 0) begin
          burst.push_back('{hold_idx[hold_head], hold_val[hold_head], 1'b0});
          hold_head = (hold_head + 1) % PRE_MAX;
          hold_fill--;
        end
        hold_head = 0;
      end
    end

    if (ge) burst.push_back('{idx, w, 1'b0});

    if (lt && peak_open) begin
      if (post_sent < post_limit_q) begin
        burst.push_back('{idx, w, 1'b0});
        post_sent++;
      end else begin
        // Post window used up: rearm and drop this sample.
        peak_open = 1'b0;
        post_sent = '0;
      end
    end

    packet_pos++;
    words_left--;
    if (burst.size() > 0) begin
      burst[burst.size() - 1].last = 1'b1;
      if (burst.size() > max_burst) max_burst = burst.size();
    end
    foreach (burst[i]) pending_points.push_back(burst[i]);
  endfunction

  // Pick a float a random distance above or below the threshold in IEEE order.
  function automatic logic [WORD_W-1:0] float_near_threshold(input bit above);
    logic [32:0] k;
    logic [31:0] key;
    logic [31:0] d;
    key = order_key(threshold_q);
    d = $urandom & ((32'd1 << $urandom_range(24)) - 32'd1);
    if (above) k = {1'b0, key} + {1'b0, d};
    else k = {1'b0, key} - {1'b0, d} - 33'd1;
    if (k[32]) k = above ? 33'h0_FFFF_FFFF : 33'd0;
    if (k[31]) return {1'b0, k[30:0]};
    return {1'b1, 31'(32'h8000_0000 - k[31:0])};
  endfunction

  // Mostly well-formed packets with random content; a few raw words as noise.
  function automatic logic [WORD_W-1:0] next_random_word();
    logic [LEN_W-1:0] len;
    logic [TS_W-1:0]  ts;
    int               pick;
    if (words_left == 0) begin
      pick = $urandom_range(99);
      if (pick < 25) len = '0;
      else if (pick < 28) len = LEN_W'($urandom_range(255, 25));
      else len = LEN_W'($urandom_range(24, 1));
      pick = $urandom_range(19);
      ts = (pick == 0) ? '0 : (pick == 1) ? '1 : TS_W'($urandom);
      level_high = 1'b0;
      return {len, ts};
    end
    if ($urandom_range(99) < 6) return $urandom;
    // Long quiet runs so the pre-trigger store fills, shorter peaks.
    if ($urandom_range(99) < (level_high ? 30 : 8)) level_high = !level_high;
    return float_near_threshold(level_high);
  endfunction

  // Present one request and hold it until the block takes it.
  task automatic send_word(input logic [WORD_W-1:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_event_word <= w;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_points(w);
    words_sent++;
  endtask

  // Hold off the sender until every predicted point has been popped, then let
  // words that cause no point (headers, stored samples) work through the pipe.
  task automatic settle_block();
    push <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] which, input logic [WORD_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= which;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (which)
      REG_RATIO:      ratio_q      = data[RATIO_W-1:0];
      REG_THRESHOLD:  threshold_q  = data;
      REG_PRE_COUNT:  pre_keep_q   = data[PRE_CNT_W-1:0];
      REG_POST_COUNT: post_limit_q = data[POST_CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [RATIO_W-1:0] ratio, input logic [WORD_W-1:0] thr,
                           input logic [PRE_CNT_W-1:0] pre, input logic [POST_CNT_W-1:0] post);
    settle_block();
    write_reg(REG_RATIO, 32'(ratio));
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_PRE_COUNT, 32'(pre));
    write_reg(REG_POST_COUNT, 32'(post));
  endtask

  // TDC hits: index scaling, round half up, saturation and a zero ratio.
  task automatic test_tdc_hits();
    configure(RATIO_RESET, 32'h0, 5'd0, 16'd0);
    send_word({8'd0, 24'h00_0000});
    send_word({8'd0, 24'hFF_FFFF});
    configure(24'h00_8000, 32'h0, 5'd0, 16'd0);
    send_word({8'd0, 24'h00_0001});
    send_word({8'd0, 24'h00_0003});
    configure(24'hFF_FFFF, 32'h0, 5'd0, 16'd0);
    send_word({8'd0, 24'hFF_FFFF});
    configure(24'h00_0000, 32'h0, 5'd0, 16'd0);
    send_word({8'd0, 24'($urandom)});
  endtask

  // Signed zeros compare equal; NaN samples and a NaN threshold are ignored.
  task automatic test_signed_zero_and_nan();
    configure(RATIO_RESET, 32'h0000_0000, 5'd2, 16'd1);
    send_word({8'd5, 24'h00_0005});
    send_word(32'h8000_0000);  // -0 against +0: crossing
    send_word(32'h7FC0_0000);  // NaN: no effect
    send_word(32'hBF80_0000);  // -1.0: post sample
    send_word(32'hC000_0000);  // -2.0: rearm, dropped
    send_word(32'h7F80_0000);  // +inf: new crossing, empty store
    configure(RATIO_RESET, 32'hFFC0_0000, 5'd2, 16'd1);
    send_word({8'd2, 24'h00_0100});
    send_word(32'h0000_0000);
    send_word(32'hFF80_0000);
  endtask

  // Lower the keep count mid-packet, cross with keep zero, then flush stale content.
  task automatic test_pre_count_changes();
    configure(RATIO_RESET, 32'h3F80_0000, 5'd4, 16'd0);
    send_word({8'd8, 24'h00_0040});
    send_word(32'h3F00_0000);
    send_word(32'h3E80_0000);
    send_word(32'h0000_0001);
    settle_block();
    write_reg(REG_PRE_COUNT, 32'd1);
    send_word(32'hBF80_0000);  // trims the store down to this one entry
    settle_block();
    write_reg(REG_PRE_COUNT, 32'd0);
    send_word(32'h4000_0000);  // crossing without a flush
    send_word(32'h3F00_0000);  // rearm
    settle_block();
    write_reg(REG_PRE_COUNT, 32'd2);
    send_word(32'h3E00_0000);  // joins the stale entry
    send_word(32'h3F80_0000);  // equal to threshold: flush both, then emit
  endtask

  // Base index just under the maximum so base plus position saturates.
  task automatic test_index_saturation();
    configure(24'hFF_FD8E, 32'h0, 5'd0, 16'd0);
    send_word({8'd4, 24'h80_0139});
    repeat (4) send_word({1'b0, 8'($urandom_range(254, 1)), 23'($urandom)});
  endtask

  // One register setting, then a stream of random requests under it.
  task automatic run_random_setting(input int setting);
    int n;
    n = 50;
    case (setting)
      0: configure(RATIO_RESET, 32'h3F80_0000, 5'd16, 16'd3);
      1: configure(24'hFF_FFFF, 32'h0000_0000, 5'd5, 16'd0);
      2: configure(24'h00_0000, 32'hBF00_0000, 5'd0, 16'hFFFF);
      3: configure(24'($urandom), 32'h42C8_0000, 5'd31, 16'($urandom_range(8)));
      4: begin
        configure(24'h00_8000, 32'hFFFF_FFFF, 5'd16, 16'd1);
        n = 20;
      end
      5: configure(24'($urandom), 32'h8000_0000, 5'($urandom_range(16)),
                   16'($urandom_range(4)));
      6: begin
        configure(24'($urandom), {1'($urandom), 8'($urandom_range(254)), 23'($urandom)},
                  5'd16, 16'd2);
        n = 60;
      end
      7: begin
        configure(24'h00_0001, 32'hC2C8_0000, 5'd9, 16'd6);
        n = 60;
      end
      default: begin
        configure(24'($urandom), 32'h3F80_0000, 5'd16, 16'd1);
        n = 60;
      end
    endcase
    repeat (n) send_word(next_random_word());
  endtask

  task automatic test_random_traffic(input int first_setting);
    for (int s = first_setting; s < first_setting + 3; s++) run_random_setting(s);
  endtask

  function automatic void note_mismatch(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    fail_count++;
    $display("t=%0t %s mismatch: expected %h, got %h", $time, field, want, got);
  endfunction

  // Pop at random and compare each popped point with the oldest prediction.
  always @(posedge clk) begin : point_check
    point_t want;
    if (rst_n && pop && !empty) begin
      points_checked++;
      if (pending_points.size() == 0) begin
        fail_count++;
        $display("t=%0t unexpected point: expected none, got idx %h val %h last %b",
                 $time, out_sample_index, out_value_bits, out_last_of_run);
      end else begin
        want = pending_points.pop_front();
        if (out_sample_index !== want.idx)
          note_mismatch("sample_index", 32'(want.idx), 32'(out_sample_index));
        if (out_value_bits !== want.val)
          note_mismatch("value_bits", want.val, out_value_bits);
        if (out_last_of_run !== want.last)
          note_mismatch("last_of_run", 32'(want.last), 32'(out_last_of_run));
      end
    end
    pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_tdc_hits();
    test_signed_zero_and_nan();
    test_pre_count_changes();
    test_index_saturation();

    // Sender slow, receiver slower; then swapped; then both at full rate.
    test_random_traffic(0);
    send_idle_pct = 49;
    recv_idle_pct = 37;
    test_random_traffic(3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(6);

    settle_block();
    if (pending_points.size() != 0) fail_count++;
    $display("Covered %0d event words: %0d TDC hits, %0d threshold crossings",
             words_sent, tdc_hits, crossings);
    $display("Checked %0d points, largest set from one word %0d, %0d errors",
             points_checked, max_burst, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
